FILE: rtl/sttok_pkg.sv
package sttok_pkg;

    // Scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Token kinds
    localparam logic [3:0] KIND_IDENT    = 4'd0;
    localparam logic [3:0] KIND_NUMBER   = 4'd1;
    localparam logic [3:0] KIND_OPEN     = 4'd2;
    localparam logic [3:0] KIND_CLOSE    = 4'd3;
    localparam logic [3:0] KIND_OPERATOR = 4'd4;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd5;
    localparam logic [3:0] KIND_END      = 4'd6;
    localparam logic [3:0] KIND_RETURN   = 4'd7;
    localparam logic [3:0] KIND_FUNCTION = 4'd8;

    localparam int RETURN_LEN   = 6;
    localparam int FUNCTION_LEN = 8;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [7:0]  length;
        logic        last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c == "%" || c == "/" || c == "*" || c == "+" ||
               c == "-" || c == "=" || c == "<";
    endfunction

    function automatic logic [7:0] return_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "r";
            3'd1:    ch = "e";
            3'd2:    ch = "t";
            3'd3:    ch = "u";
            3'd4:    ch = "r";
            3'd5:    ch = "n";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] function_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "f";
            3'd1:    ch = "u";
            3'd2:    ch = "n";
            3'd3:    ch = "c";
            3'd4:    ch = "t";
            3'd5:    ch = "i";
            3'd6:    ch = "o";
            default: ch = "n";
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/source_text_tokenizer_top.sv
// Source text tokenizer. Takes one byte of text, or an end-of-input flag,
// per request and reports tokens by kind, start offset and length. A request
// is normally accepted every cycle. A request that ends an identifier or a
// number and also forms a token of its own (or an end flag after a pending
// token) gives two results; these sit in a three-entry result queue, and
// s_ready drops while more than one result is waiting, so the sustained
// rate is one request per cycle as long as the output side drains one
// result per cycle, with a pause after each two-result request.
// Results are registered in the result queue before they reach the output.
module source_text_tokenizer_top
    import sttok_pkg::*;
#(
    parameter int LENGTH_BITS   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [7:0]  m_token_length,
    output logic        m_last_of_run
);

    logic       accept;
    logic       room;
    token_t     tok0;
    token_t     tok1;
    token_t     m_tok;
    logic [1:0] push_count;

    assign s_ready = room;
    assign accept  = s_valid && room;

    sttok_lexer #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .text_byte    (s_text_byte),
        .end_of_input (s_end_of_input),
        .tok0         (tok0),
        .tok1         (tok1),
        .push_count   (push_count)
    );

    sttok_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tok0       (tok0),
        .tok1       (tok1),
        .push_count (push_count),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tok      (m_tok)
    );

    assign m_token_kind   = m_tok.kind;
    assign m_token_start  = m_tok.start;
    assign m_token_length = m_tok.length;
    assign m_last_of_run  = m_tok.last;

endmodule

FILE: rtl/sttok_lexer.sv
module sttok_lexer
    import sttok_pkg::*;
#(
    parameter int LENGTH_BITS   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       end_of_input,
    output token_t     tok0,
    output token_t     tok1,
    output logic [1:0] push_count
);

    logic [1:0]               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [1:0]               flags_reg, flags_next;

    logic                     pend_valid;
    token_t                   pend_tok;
    logic                     single_valid;
    token_t                   single_tok;
    logic [LENGTH_BITS+7:0]   len_ext;
    logic [7:0]               len_out;
    logic                     grows;

    always_comb begin
        len_ext = (LENGTH_BITS+8)'(len_reg);
        len_out = (len_ext > (LENGTH_BITS+8)'(255)) ? 8'hFF : len_ext[7:0];

        // The token under construction, reported when something ends it.
        pend_valid      = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
        pend_tok.start  = 32'(start_reg);
        pend_tok.length = len_out;
        pend_tok.last   = 1'b0;
        if (mode_reg == MODE_NUMBER) begin
            pend_tok.kind = KIND_NUMBER;
        end else if (flags_reg[0] && len_reg == LENGTH_BITS'(RETURN_LEN)) begin
            pend_tok.kind = KIND_RETURN;
        end else if (flags_reg[1] && len_reg == LENGTH_BITS'(FUNCTION_LEN)) begin
            pend_tok.kind = KIND_FUNCTION;
        end else begin
            pend_tok.kind = KIND_IDENT;
        end

        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        single_valid      = 1'b0;
        single_tok.kind   = KIND_UNKNOWN;
        single_tok.start  = 32'(pos_reg);
        single_tok.length = 8'd1;
        single_tok.last   = 1'b1;

        grows = !end_of_input &&
                (((mode_reg == MODE_IDENT) && (is_letter(text_byte) || is_digit(text_byte)))
              || ((mode_reg == MODE_NUMBER) && (is_digit(text_byte) || text_byte == ".")));

        if (end_of_input) begin
            single_valid      = 1'b1;
            single_tok.kind   = KIND_END;
            single_tok.length = 8'd0;
            mode_next  = MODE_IDLE;
            len_next   = '0;
            flags_next = 2'b11;
        end else if (grows) begin
            pend_valid = 1'b0;
            if (!(len_reg < LENGTH_BITS'(RETURN_LEN) &&
                  return_char(len_reg[2:0]) == text_byte)) begin
                flags_next[0] = 1'b0;
            end
            if (!(len_reg < LENGTH_BITS'(FUNCTION_LEN) &&
                  function_char(len_reg[2:0]) == text_byte)) begin
                flags_next[1] = 1'b0;
            end
            if (len_reg != '1) begin
                len_next = len_reg + 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end else begin
            mode_next  = MODE_IDLE;
            len_next   = '0;
            flags_next = 2'b11;
            pos_next   = pos_reg + 1'b1;
            if (is_space(text_byte)) begin
                single_valid = 1'b0;
            end else if (is_letter(text_byte) || is_digit(text_byte)) begin
                mode_next  = is_letter(text_byte) ? MODE_IDENT : MODE_NUMBER;
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
                flags_next = {text_byte == "f", text_byte == "r"};
            end else begin
                single_valid = 1'b1;
                if (text_byte == "(") begin
                    single_tok.kind = KIND_OPEN;
                end else if (text_byte == ")") begin
                    single_tok.kind = KIND_CLOSE;
                end else if (is_operator(text_byte)) begin
                    single_tok.kind = KIND_OPERATOR;
                end else begin
                    single_tok.kind = KIND_UNKNOWN;
                end
            end
        end

        // Pack the results so that the first produced is always in slot 0.
        pend_tok.last = !single_valid;
        if (pend_valid) begin
            tok0 = pend_tok;
            tok1 = single_tok;
        end else begin
            tok0 = single_tok;
            tok1 = single_tok;
        end
        if (!accept) begin
            push_count = 2'd0;
        end else begin
            push_count = 2'(pend_valid) + 2'(single_valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            flags_reg <= 2'b11;
        end else if (accept) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: rtl/sttok_out_queue.sv
module sttok_out_queue
    import sttok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  token_t     tok0,
    input  token_t     tok1,
    input  logic [1:0] push_count,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output token_t     m_tok
);

    localparam logic [1:0] DEPTH_LAST = 2'd2;

    token_t     entry_reg [3];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] wr_ptr_plus1;
    logic       pop;

    function automatic logic [1:0] wrap_inc(input logic [1:0] p);
        return (p == DEPTH_LAST) ? 2'd0 : p + 2'd1;
    endfunction

    assign pop          = m_valid && m_ready;
    assign m_valid      = (count_reg != 2'd0);
    assign m_tok        = entry_reg[rd_ptr_reg];
    // Room for the worst case of two results from one request.
    assign room         = (count_reg <= 2'd1);
    assign wr_ptr_plus1 = wrap_inc(wr_ptr_reg);

    always_comb begin
        count_next  = count_reg + push_count - 2'(pop);
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (push_count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            default: wr_ptr_next = wrap_inc(wr_ptr_plus1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= tok0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= tok1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> (count_reg <= 2'd1))
        else $error("result queue written without room");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg != 2'd3) && (rd_ptr_reg != 2'd3))
        else $error("queue pointer out of range");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue empty but pointers differ");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |=> m_valid)
        else $error("pushed result not presented");
`endif

endmodule
